// ===== design/ddct_pkg.sv =====
// Shared types and constants for the debounced double-click toggle.
`timescale 1ns / 1ps

package ddct_pkg;

    localparam int TICK_W = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [TICK_W-1:0] DEBOUNCE_TICKS_RST = 16'd50;
    localparam logic [TICK_W-1:0] WINDOW_TICKS_RST = 16'd1000;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS = 2'd1;

    typedef struct packed {
        logic [TICK_W-1:0] debounce_ticks;
        logic [TICK_W-1:0] window_ticks;
    } cfg_t;

    typedef struct packed {
        logic toggled;
        logic first_click;
        logic active;
    } result_t;

endpackage

// ===== design/ddct_cfg_regs.sv =====
// Configuration register file: debounce and window lengths.
`timescale 1ns / 1ps

module ddct_cfg_regs
    import ddct_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [TICK_W-1:0]    wr_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (wr_index)
                REG_DEBOUNCE_TICKS: cfg_next.debounce_ticks = wr_data;
                REG_WINDOW_TICKS:   cfg_next.window_ticks = wr_data;
                default:            cfg_next = cfg_reg; // unknown index: ignored
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ticks <= DEBOUNCE_TICKS_RST;
            cfg_reg.window_ticks <= WINDOW_TICKS_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/ddct_tick_core.sv =====
// Per-tick state update: debounce timer, click window and the two flags.
`timescale 1ns / 1ps

module ddct_tick_core
    import ddct_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    tick_en,
    input  logic    level,
    input  cfg_t    cfg,
    output result_t result
);

    logic              last_level_reg, last_level_next;
    logic [TICK_W-1:0] deb_count_reg, deb_count_next;
    logic              deb_run_reg, deb_run_next;
    logic              deb_aims_reg, deb_aims_next;
    logic [TICK_W-1:0] win_count_reg, win_count_next;
    logic              win_run_reg, win_run_next;
    logic              pending_reg, pending_next;
    logic              active_reg, active_next;
    logic              toggled;
    logic              deb_expire;
    logic              win_expire;

    always_comb begin
        last_level_next = last_level_reg;
        deb_count_next = deb_count_reg;
        deb_run_next = deb_run_reg;
        deb_aims_next = deb_aims_reg;
        win_count_next = win_count_reg;
        win_run_next = win_run_reg;
        pending_next = pending_reg;
        active_next = active_reg;
        toggled = 1'b0;

        // debounce timer first; a load of 0 or 1 both expire on the next tick
        deb_expire = deb_run_reg && (deb_count_reg <= TICK_W'(1));
        if (deb_expire) begin
            deb_count_next = '0;
            deb_run_next = 1'b0;
            if (level) begin
                if (deb_aims_reg) begin
                    active_next = ~active_reg;
                    toggled = 1'b1;
                    pending_next = 1'b0;
                    win_run_next = 1'b0;
                    win_count_next = '0;
                end else begin
                    pending_next = ~pending_reg;
                end
            end
        end else if (deb_run_reg) begin
            deb_count_next = deb_count_reg - TICK_W'(1);
        end

        // window timer sees the state left by the debounce expiry
        win_expire = win_run_next && (win_count_next <= TICK_W'(1));
        if (win_expire) begin
            win_count_next = '0;
            win_run_next = 1'b0;
            pending_next = 1'b0;
        end else if (win_run_next) begin
            win_count_next = win_count_next - TICK_W'(1);
        end

        // edge handling last
        if (level != last_level_reg) begin
            deb_count_next = cfg.debounce_ticks;
            deb_run_next = 1'b1;
            deb_aims_next = pending_next;
            if (!pending_next) begin
                win_count_next = cfg.window_ticks;
                win_run_next = 1'b1;
            end
            last_level_next = level;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_level_reg <= 1'b1;
            deb_count_reg <= '0;
            deb_run_reg <= 1'b0;
            deb_aims_reg <= 1'b0;
            win_count_reg <= '0;
            win_run_reg <= 1'b0;
            pending_reg <= 1'b0;
            active_reg <= 1'b0;
        end else if (tick_en) begin
            last_level_reg <= last_level_next;
            deb_count_reg <= deb_count_next;
            deb_run_reg <= deb_run_next;
            deb_aims_reg <= deb_aims_next;
            win_count_reg <= win_count_next;
            win_run_reg <= win_run_next;
            pending_reg <= pending_next;
            active_reg <= active_next;
        end
    end

    assign result.active = active_next;
    assign result.first_click = pending_next;
    assign result.toggled = toggled;

endmodule

// ===== design/ddct_out_buf.sv =====
// Two-entry result buffer between the tick core and the output channel.
`timescale 1ns / 1ps

module ddct_out_buf
    import ddct_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    wr_valid,
    output logic    wr_ready,
    input  result_t wr_data,
    output logic    rd_valid,
    input  logic    rd_ready,
    output result_t rd_data
);

    result_t    slot_reg [2];
    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic       push;
    logic       pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data = slot_reg[rd_ptr_reg];
    assign push = wr_valid && wr_ready;
    assign pop = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== design/debounced_double_click_toggle.sv =====
// Top level of the debounced double-click toggle.
`timescale 1ns / 1ps
//
// Usage:
//   s_ channel: one item per timer tick, s_tdata[0] = raw pin level.
//   m_ channel: one item per input item: active, first_click, toggled.
//   cfg channel: cfg_index 0 = debounce ticks, 1 = window ticks; other
//     indexes are ignored. Always ready; write only while idle.
// Each result is registered into the result buffer when its input item is accepted.
// Throughput: one item per cycle while the buffer has room. The whole tick
//   update (two down counters, edge detect, flag toggles) sits between the state
//   registers and a two-entry result buffer, so nothing iterates.
// Stall: while m_tready is low the buffer holds up to two results; s_tready
//   drops only when both entries are occupied. No item is lost or repeated.
// Reset (aresetn low, synchronous): pin history reads high, timers stopped,
//   flags clear, buffer empty, registers back to 50 and 1000 ticks.
// A length of 0 acts as 1. New lengths apply at the next timer load.

module debounced_double_click_toggle
    import ddct_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [0] pin_level, [7:1] zero
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // [0] active, [1] first_click,
                                            // [2] toggled, [7:3] zero
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TICK_W-1:0]    cfg_data
);

    cfg_t    cfg;
    result_t tick_result;
    result_t out_result;
    logic    accept;
    logic    buf_ready;

    assign cfg_ready = 1'b1;
    assign s_tready = buf_ready;
    assign accept = s_tvalid && buf_ready;

    ddct_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    ddct_tick_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tick_en (accept),
        .level   (s_tdata[0]),
        .cfg     (cfg),
        .result  (tick_result)
    );

    ddct_out_buf u_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (s_tvalid),
        .wr_ready (buf_ready),
        .wr_data  (tick_result),
        .rd_valid (m_tvalid),
        .rd_ready (m_tready),
        .rd_data  (out_result)
    );

    assign m_tdata = {5'b0, out_result.toggled, out_result.first_click, out_result.active};

endmodule

// ===== design/ddct_checker.sv =====
// Port-level checks for the debounced double-click toggle, bound to the top.
`timescale 1ns / 1ps

module ddct_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a toggle clears the pending first click in the same tick
    a_toggle_clears_first: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2] |-> !m_tdata[1])
        else $error("toggle with first click still pending");

    // input back-pressure only while results are waiting
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result waiting");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind debounced_double_click_toggle ddct_checker u_ddct_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
